### hw/rtl/afp_pkg.sv
package afp_pkg;

  // configuration register indexes
  localparam int unsigned NUM_CODES = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INCFG_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_CODE  = 3'd4;

  // reset values of the frame codes
  localparam logic [7:0] RST_DATA_CODE  = 8'd132;
  localparam logic [7:0] RST_SKIP_CODE  = 8'd64;
  localparam logic [7:0] RST_TIME_CODE  = 8'd68;
  localparam logic [7:0] RST_INCFG_CODE = 8'd72;
  localparam logic [7:0] RST_DROP_CODE  = 8'd80;

  localparam logic [7:0] HDR_MASK  = 8'hFC;
  localparam logic [2:0] DATA_LEN  = 3'd7;
  localparam logic [2:0] SHORT_LEN = 3'd2;
  localparam logic [2:0] TIME_LEN  = 3'd4;

  localparam int unsigned DEF_MAX_SAMPLES = 32;
  localparam int unsigned CNT_W           = 6;
  localparam int unsigned SLOT_W          = 5;
  localparam int unsigned PAY_DEPTH       = 5;   // last payload byte is used live

  localparam logic [15:0] S16_MOST_NEG = 16'h8000;
  localparam logic [15:0] S16_MOST_POS = 16'h7FFF;

  typedef logic [NUM_CODES-1:0][7:0] code_set_t;

  // header decode: bytes still to come after the header, 0 for a lone byte
  typedef struct packed {
    logic       is_data;
    logic [2:0] left;
  } hdr_dec_t;

  typedef struct packed {
    logic [15:0]        accel_x;
    logic [15:0]        accel_y;
    logic [15:0]        accel_z;
    logic               sample_valid;
    logic [SLOT_W-1:0]  sample_slot;
    logic               burst_end;
    logic [CNT_W-1:0]   sample_total;
    logic               frame_cut;
    logic               samples_dropped;
  } result_t;

  function automatic logic [15:0] neg_sat(input logic [15:0] v);
    logic [15:0] r;
    begin
      if (v == S16_MOST_NEG) r = S16_MOST_POS;
      else                   r = 16'(~v + 16'd1);
      return r;
    end
  endfunction

endpackage

### hw/rtl/afp_hdr_dec.sv
module afp_hdr_dec
  import afp_pkg::*;
(
  input  logic [7:0] hdr_byte,
  input  code_set_t  codes,
  output hdr_dec_t   dec
);

  logic [7:0] h;
  logic       m_data, m_skip, m_time, m_incfg, m_drop;

  assign h       = hdr_byte & HDR_MASK;
  assign m_data  = (h == codes[CFG_DATA_CODE]);
  assign m_skip  = (h == codes[CFG_SKIP_CODE]);
  assign m_time  = (h == codes[CFG_TIME_CODE]);
  assign m_incfg = (h == codes[CFG_INCFG_CODE]);
  assign m_drop  = (h == codes[CFG_DROP_CODE]);

  // first code in register order wins
  always_comb begin
    dec = '0;
    if (m_data) begin
      dec.is_data = 1'b1;
      dec.left    = 3'(DATA_LEN - 3'd1);
    end else if (m_skip || (!m_time && (m_incfg || m_drop))) begin
      dec.left = 3'(SHORT_LEN - 3'd1);
    end else if (m_time) begin
      dec.left = 3'(TIME_LEN - 3'd1);
    end
  end

endmodule

### hw/rtl/afp_frame_core.sv
module afp_frame_core
  import afp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  input  hdr_dec_t   dec,
  input  logic       res_stall,
  output logic       go,
  output logic       res_vld,
  output result_t    res
);

  localparam int unsigned LIMIT_I = (MAX_SAMPLES < 1) ? 1 :
                                    (MAX_SAMPLES > 63) ? 63 : MAX_SAMPLES;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_I);

  logic [2:0]       left_r, left_nxt;
  logic             data_r, data_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       pay_r [PAY_DEPTH];
  logic             res_vld_r, res_vld_nxt;
  result_t          res_r, res_nxt;

  logic       proc, complete, keep, emit, pay_we;
  logic [2:0] pay_idx, left_step;

  assign go      = !res_vld_r || !res_stall;
  assign proc    = item_vld && go;
  assign pay_idx = 3'(DATA_LEN - 3'd1) - left_r;
  assign pay_we  = proc && (left_r != 3'd0) && data_r && (pay_idx < 3'(PAY_DEPTH));

  assign left_step = (left_r == 3'd0) ? dec.left : 3'(left_r - 3'd1);
  assign complete  = (left_r == 3'd1) && data_r;
  assign keep      = complete && (kept_r < LIMIT);
  assign emit      = keep || item_last;

  always_comb begin
    left_nxt    = left_r;
    data_nxt    = data_r;
    kept_nxt    = kept_r;
    ovf_nxt     = ovf_r;
    res_vld_nxt = res_vld_r;
    res_nxt     = res_r;
    if (go) res_vld_nxt = proc && emit;
    if (proc) begin
      left_nxt = left_step;
      if (left_r == 3'd0) data_nxt = dec.is_data;
      else if (left_r == 3'd1) data_nxt = 1'b0;
      if (keep) kept_nxt = CNT_W'(kept_r + 1'b1);
      if (complete && !keep) ovf_nxt = 1'b1;

      res_nxt = '0;
      if (keep) begin
        res_nxt.accel_x      = {pay_r[1], pay_r[0]};
        res_nxt.accel_y      = neg_sat({pay_r[3], pay_r[2]});
        res_nxt.accel_z      = neg_sat({item_byte, pay_r[4]});
        res_nxt.sample_valid = 1'b1;
        res_nxt.sample_slot  = kept_r[SLOT_W-1:0];
      end
      res_nxt.burst_end       = item_last;
      res_nxt.frame_cut       = item_last && (left_step != 3'd0);
      res_nxt.sample_total    = kept_nxt;
      res_nxt.samples_dropped = ovf_nxt;

      // burst end returns the per-burst state to idle
      if (item_last) begin
        left_nxt = 3'd0;
        data_nxt = 1'b0;
        kept_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= 3'd0;
      data_r    <= 1'b0;
      kept_r    <= '0;
      ovf_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      left_r    <= left_nxt;
      data_r    <= data_nxt;
      kept_r    <= kept_nxt;
      ovf_r     <= ovf_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (pay_we) pay_r[pay_idx] <= item_byte;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

### hw/rtl/accel_fifo_frame_parser_unit.sv
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_valid / in_stall    | fifo_byte[7:0], burst_last
// out_    | out | out_valid / out_stall  | accel_x/y/z, sample_valid, sample_slot,
//         |     |                        | burst_end, sample_total, frame_cut,
//         |     |                        | samples_dropped
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[7:0]
//
// One byte a cycle sustained while in_stall is low. An accepted item is held
// in the input register, then its result (if any) is registered in the output
// register. Synchronous active-low reset clears the frame tracker, counters
// and valids; codes return to their defaults. out_stall holds the output
// register; the input register then fills and in_stall is high while both
// are occupied and out_stall is high. cfg_ready is always high.
module accel_fifo_frame_parser_unit
  import afp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_fifo_byte,
  input  logic                 in_burst_last,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_accel_x,
  output logic signed [15:0]   out_accel_y,
  output logic signed [15:0]   out_accel_z,
  output logic                 out_sample_valid,
  output logic [SLOT_W-1:0]    out_sample_slot,
  output logic                 out_burst_end,
  output logic [CNT_W-1:0]     out_sample_total,
  output logic                 out_frame_cut,
  output logic                 out_samples_dropped,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // frame code registers, in register-index order
  code_set_t codes_r, codes_nxt;

  // input register
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       s1_last_r, s1_last_nxt;

  logic     go, res_vld;
  hdr_dec_t dec;
  result_t  res;

  assign cfg_ready = 1'b1;

  // indexes past the last code are accepted and dropped
  always_comb begin
    codes_nxt = codes_r;
    if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CODES)))
      codes_nxt[cfg_index] = cfg_data;
  end

  // input register only holds while the core is blocked by a full output
  assign in_stall = s1_vld_r && !go;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_byte_nxt = s1_byte_r;
    s1_last_nxt = s1_last_r;
    if (!in_stall) begin
      s1_vld_nxt  = in_valid;
      s1_byte_nxt = in_fifo_byte;
      s1_last_nxt = in_burst_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[CFG_DATA_CODE]  <= RST_DATA_CODE;
      codes_r[CFG_SKIP_CODE]  <= RST_SKIP_CODE;
      codes_r[CFG_TIME_CODE]  <= RST_TIME_CODE;
      codes_r[CFG_INCFG_CODE] <= RST_INCFG_CODE;
      codes_r[CFG_DROP_CODE]  <= RST_DROP_CODE;
      s1_vld_r                <= 1'b0;
    end else begin
      codes_r  <= codes_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    s1_last_r <= s1_last_nxt;
  end

  // header match is only used by the core when it expects a header
  afp_hdr_dec u_hdr_dec (
    .hdr_byte (s1_byte_r),
    .codes    (codes_r),
    .dec      (dec)
  );

  // frame tracking, sample assembly and the output register
  afp_frame_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_frame_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (s1_vld_r),
    .item_byte (s1_byte_r),
    .item_last (s1_last_r),
    .dec       (dec),
    .res_stall (out_stall),
    .go        (go),
    .res_vld   (res_vld),
    .res       (res)
  );

  assign out_valid           = res_vld;
  assign out_accel_x         = $signed(res.accel_x);
  assign out_accel_y         = $signed(res.accel_y);
  assign out_accel_z         = $signed(res.accel_z);
  assign out_sample_valid    = res.sample_valid;
  assign out_sample_slot     = res.sample_slot;
  assign out_burst_end       = res.burst_end;
  assign out_sample_total    = res.sample_total;
  assign out_frame_cut       = res.frame_cut;
  assign out_samples_dropped = res.samples_dropped;

endmodule

### hw/rtl/afp_checker.sv
module afp_checker
  import afp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [15:0]  out_accel_x,
  input logic signed [15:0]  out_accel_y,
  input logic signed [15:0]  out_accel_z,
  input logic                out_sample_valid,
  input logic [SLOT_W-1:0]   out_sample_slot,
  input logic                out_burst_end,
  input logic [CNT_W-1:0]    out_sample_total,
  input logic                out_frame_cut
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accel_x)
      && $stable(out_sample_total) && $stable(out_burst_end))
    else $error("stalled result changed");

  // a result without a sample carries zero sample fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |->
      out_accel_x == 16'sd0 && out_accel_y == 16'sd0 && out_accel_z == 16'sd0
      && out_sample_slot == '0)
    else $error("sample fields set without a sample");

  // cut frames only reported at burst end
  a_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_burst_end |-> !out_frame_cut)
    else $error("frame_cut outside burst end");

  // the total counts the sample just emitted
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_valid |->
      out_sample_total[SLOT_W-1:0] == SLOT_W'(out_sample_slot + 1'b1))
    else $error("sample_total out of step with sample_slot");

  // negated axes saturate
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_valid |->
      out_accel_y != -16'sd32768 && out_accel_z != -16'sd32768)
    else $error("negated axis not saturated");

endmodule

bind accel_fifo_frame_parser_unit afp_checker u_afp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_accel_x      (out_accel_x),
  .out_accel_y      (out_accel_y),
  .out_accel_z      (out_accel_z),
  .out_sample_valid (out_sample_valid),
  .out_sample_slot  (out_sample_slot),
  .out_burst_end    (out_burst_end),
  .out_sample_total (out_sample_total),
  .out_frame_cut    (out_frame_cut)
);
